/* hw/rtl/cluster_topology_hash_assert.svh */
// assertion macros for the cluster topology hash checker
// depends on nothing; taken in by the checker file through an include
`ifndef CLUSTER_TOPOLOGY_HASH_ASSERT_SVH
`define CLUSTER_TOPOLOGY_HASH_ASSERT_SVH

// same-cycle implication, off while reset is high
`define CTH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define CTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that is also checked during reset
`define CTH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cth_pkg.sv */
// shared constants, command type and back-end states of the cluster topology hash
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package cth_pkg;

   localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
   localparam logic [31:0] HASH_SEED = 32'hdeadbeef;
   localparam int          SHIFT_K   = 24;
   localparam int          SHIFT_A   = 13;
   localparam int          SHIFT_B   = 15;

   // byte count of one cluster, up to ceil(255*255/8)
   localparam int CNT_W = 13;
   // pattern bytes kept for the low word of the result
   localparam int LOW_BYTES = 4;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one command: bytes to hash plus cluster start / end markers
   typedef struct packed {
      logic             start;
      logic             empty;
      logic             finish;
      logic [1:0]       feed_count;
      logic [23:0]      feed_bytes;
      logic [CNT_W-1:0] byte_total;
      logic [31:0]      low_word;
   } cth_cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MIX_A,
      BK_MIX_B,
      BK_FIN_T,
      BK_FIN_A,
      BK_EMIT
   } cth_back_state_type;

   // low 32 bits of a times the mix multiplier
   function automatic logic [31:0] mix_mul(input logic [31:0] a);
      return a * MIX_MUL;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/cth_if.sv */
// valid/ready channels of the cluster topology hash: request and response
// depends on cth_pkg for nothing but kept after it in compile order
`timescale 1ns / 1ps
`default_nettype none

interface cth_req_if;
   logic       valid;
   logic       ready;
   logic       first;
   logic [7:0] row_count;
   logic [7:0] col_count;
   logic [7:0] pattern_byte;

   modport source (output valid, output first, output row_count, output col_count,
                   output pattern_byte, input ready);
   modport sink   (input valid, input first, input row_count, input col_count,
                   input pattern_byte, output ready);
endinterface

interface cth_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] topology_hash;
   logic        empty_error;

   modport source (output valid, output topology_hash, output empty_error, input ready);
   modport sink   (input valid, input topology_hash, input empty_error, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cth_front.sv */
// front end: accepts items, tracks the cluster byte count, emits hash commands
// depends on cth_pkg and cth_if
`timescale 1ns / 1ps
`default_nettype none

module cth_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   cth_req_if.sink                   req_ch,
   input  wire logic                 cmd_full,
   output cth_pkg::cth_cmd_type      cmd_data,
   output logic                      cmd_push
);

   logic [cth_pkg::CNT_W-1:0] taken_ff, taken_in;
   logic [cth_pkg::CNT_W-1:0] expected_ff, expected_in;
   logic [31:0]               low_ff, low_in;

   logic                      accept;
   logic                      active;
   logic [15:0]               area;
   logic [16:0]               area_up;
   logic [cth_pkg::CNT_W-1:0] n_first;
   logic [cth_pkg::CNT_W:0]   stream_pos;

   assign req_ch.ready = !cmd_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign active       = taken_ff < expected_ff;

   // ceil(rows * cols / 8)
   assign area    = {8'd0, req_ch.row_count} * {8'd0, req_ch.col_count};
   assign area_up = {1'b0, area} + 17'd7;
   assign n_first = area_up[16:3] > 14'd0 ? area_up[15:3] : '0;

   // stream position of this pattern byte behind the two header bytes
   assign stream_pos = {1'b0, taken_ff} + (cth_pkg::CNT_W + 1)'(2);

   always_comb begin
      taken_in    = taken_ff;
      expected_in = expected_ff;
      low_in      = low_ff;
      cmd_data    = '0;
      cmd_push    = 1'b0;
      if (accept) begin
         if (req_ch.first) begin
            cmd_data.start      = 1'b1;
            cmd_data.byte_total = n_first;
            cmd_push            = 1'b1;
            if (n_first == '0) begin
               cmd_data.empty = 1'b1;
               expected_in    = '0;
               taken_in       = '0;
               low_in         = '0;
            end else begin
               // header bytes and first pattern byte, only those below n
               if (n_first >= cth_pkg::CNT_W'(3)) begin
                  cmd_data.feed_count = 2'd3;
                  cmd_data.feed_bytes = {req_ch.pattern_byte, req_ch.col_count,
                                         req_ch.row_count};
               end else if (n_first == cth_pkg::CNT_W'(2)) begin
                  cmd_data.feed_count = 2'd2;
                  cmd_data.feed_bytes = {8'd0, req_ch.col_count, req_ch.row_count};
               end else begin
                  cmd_data.feed_count = 2'd1;
                  cmd_data.feed_bytes = {16'd0, req_ch.row_count};
               end
               low_in            = {req_ch.pattern_byte, 24'd0};
               expected_in       = n_first;
               taken_in          = cth_pkg::CNT_W'(1);
               cmd_data.finish   = n_first == cth_pkg::CNT_W'(1);
               cmd_data.low_word = {req_ch.pattern_byte, 24'd0};
            end
         end else if (active) begin
            if (stream_pos < {1'b0, expected_ff}) begin
               cmd_data.feed_count = 2'd1;
               cmd_data.feed_bytes = {16'd0, req_ch.pattern_byte};
            end
            if (taken_ff < cth_pkg::CNT_W'(cth_pkg::LOW_BYTES)) begin
               case (taken_ff[1:0])
                  2'd0:    low_in = low_ff | {req_ch.pattern_byte, 24'd0};
                  2'd1:    low_in = low_ff | {8'd0, req_ch.pattern_byte, 16'd0};
                  2'd2:    low_in = low_ff | {16'd0, req_ch.pattern_byte, 8'd0};
                  default: low_in = low_ff | {24'd0, req_ch.pattern_byte};
               endcase
            end
            taken_in          = taken_ff + cth_pkg::CNT_W'(1);
            cmd_data.finish   = taken_in == expected_ff;
            cmd_data.low_word = low_in;
            cmd_push          = cmd_data.finish || (cmd_data.feed_count != 2'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff    <= '0;
         expected_ff <= '0;
         low_ff      <= '0;
      end else begin
         taken_ff    <= taken_in;
         expected_ff <= expected_in;
         low_ff      <= low_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/cth_queue.sv */
// short command queue between front and back ends
// depends on cth_pkg
`timescale 1ns / 1ps
`default_nettype none

module cth_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cth_pkg::cth_cmd_type push_data,
   input  wire logic                 pop,
   output cth_pkg::cth_cmd_type      pop_data,
   output logic                      full,
   output logic                      empty
);

   cth_pkg::cth_cmd_type       mem_ff [cth_pkg::QUEUE_DEPTH];
   logic [cth_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [cth_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == cth_pkg::QCNT_W'(cth_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + cth_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - cth_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + cth_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + cth_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/cth_back.sv */
// back end: gathers words, runs the multiply mix and final mix, holds the result
// depends on cth_pkg and cth_if
`timescale 1ns / 1ps
`default_nettype none

module cth_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cth_pkg::cth_cmd_type cmd_data,
   input  wire logic                 cmd_empty,
   output logic                      cmd_pop,
   cth_rsp_if.source                 rsp_ch
);

   cth_pkg::cth_back_state_type state_ff, state_in;

   logic [31:0] hash_ff, hash_in;
   logic [31:0] gather_ff, gather_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] hm_ff, hm_in;
   logic        finish_ff, finish_in;
   logic        empty_ff, empty_in;
   logic [31:0] low_ff, low_in;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_hash_ff, out_hash_in;
   logic        out_err_ff, out_err_in;

   logic [31:0] h_base, g_base;
   logic [1:0]  c_base;
   logic [55:0] window;
   logic [2:0]  total;
   logic [31:0] mul_x_op, mul_x, mul_y;
   logic [31:0] k_mixed;
   logic        out_free;

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.topology_hash = out_hash_ff;
   assign rsp_ch.empty_error   = out_err_ff;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // a cluster start resets the running hash and the gathered word
   assign h_base = cmd_data.start ?
                   ({{(32 - cth_pkg::CNT_W){1'b0}}, cmd_data.byte_total} ^ cth_pkg::HASH_SEED) :
                   hash_ff;
   assign g_base = cmd_data.start ? 32'd0 : gather_ff;
   assign c_base = cmd_data.start ? 2'd0 : cnt_ff;
   assign window = {24'd0, g_base} | ({32'd0, cmd_data.feed_bytes} << {c_base, 3'b000});
   assign total  = {1'b0, c_base} + {1'b0, cmd_data.feed_count};

   assign k_mixed = k_ff ^ (k_ff >> cth_pkg::SHIFT_K);

   // shared multiplier operand, chosen by step
   always_comb begin
      case (state_ff)
         cth_pkg::BK_MIX_A: mul_x_op = word_ff;
         cth_pkg::BK_MIX_B: mul_x_op = k_mixed;
         cth_pkg::BK_FIN_T: mul_x_op = hash_ff ^ gather_ff;
         default:           mul_x_op = hash_ff ^ (hash_ff >> cth_pkg::SHIFT_A);
      endcase
   end

   assign mul_x = cth_pkg::mix_mul(mul_x_op);
   assign mul_y = cth_pkg::mix_mul(hash_ff);

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      gather_in    = gather_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      k_in         = k_ff;
      hm_in        = hm_ff;
      finish_in    = finish_ff;
      empty_in     = empty_ff;
      low_in       = low_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_hash_in  = out_hash_ff;
      out_err_in   = out_err_ff;
      cmd_pop      = 1'b0;
      case (state_ff)
         cth_pkg::BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop   = 1'b1;
               finish_in = cmd_data.finish;
               empty_in  = cmd_data.empty;
               low_in    = cmd_data.low_word;
               hash_in   = h_base;
               if (cmd_data.empty) begin
                  state_in = cth_pkg::BK_EMIT;
               end else if (total >= 3'd4) begin
                  word_in   = window[31:0];
                  gather_in = {8'd0, window[55:32]};
                  cnt_in    = 2'(total - 3'd4);
                  state_in  = cth_pkg::BK_MIX_A;
               end else begin
                  gather_in = window[31:0];
                  cnt_in    = total[1:0];
                  if (cmd_data.finish) begin
                     state_in = (total[1:0] != 2'd0) ? cth_pkg::BK_FIN_T : cth_pkg::BK_FIN_A;
                  end
               end
            end
         end
         cth_pkg::BK_MIX_A: begin
            k_in     = mul_x;
            hm_in    = mul_y;
            state_in = cth_pkg::BK_MIX_B;
         end
         cth_pkg::BK_MIX_B: begin
            hash_in = hm_ff ^ mul_x;
            if (finish_ff) begin
               state_in = (cnt_ff != 2'd0) ? cth_pkg::BK_FIN_T : cth_pkg::BK_FIN_A;
            end else begin
               state_in = cth_pkg::BK_IDLE;
            end
         end
         cth_pkg::BK_FIN_T: begin
            hash_in  = mul_x;
            state_in = cth_pkg::BK_FIN_A;
         end
         cth_pkg::BK_FIN_A: begin
            hash_in  = mul_x;
            state_in = cth_pkg::BK_EMIT;
         end
         cth_pkg::BK_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_err_in   = empty_ff;
               if (empty_ff) begin
                  out_hash_in = '0;
               end else begin
                  out_hash_in = {hash_ff ^ (hash_ff >> cth_pkg::SHIFT_B), low_ff};
               end
               state_in = cth_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = cth_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cth_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff     <= hash_in;
      gather_ff   <= gather_in;
      cnt_ff      <= cnt_in;
      word_ff     <= word_in;
      k_ff        <= k_in;
      hm_ff       <= hm_in;
      finish_ff   <= finish_in;
      empty_ff    <= empty_in;
      low_ff      <= low_in;
      out_hash_ff <= out_hash_in;
      out_err_ff  <= out_err_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/cluster_topology_hash.sv */
// result path: queue, mix and final-mix steps, EMIT; an empty cluster goes to EMIT
// throughput: items enter at one a cycle while the 4-entry command queue has room;
// the back end drains one command a cycle while idle and leaves idle for its MIX_A
// and MIX_B steps on each finished 4-byte word
// reset: synchronous, active high; clears byte counters, queue pointers, the back-end
// state and the result valid; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

// top level of the cluster topology hash
// depends on cth_pkg, cth_if, cth_front, cth_queue and cth_back
module cluster_topology_hash (
   input  wire logic clock,
   input  wire logic reset,
   cth_req_if.sink   req_ch,
   cth_rsp_if.source rsp_ch
);

   // front to queue
   cth_pkg::cth_cmd_type push_cmd;
   logic                 push;
   logic                 q_full;

   // queue to back
   cth_pkg::cth_cmd_type head_cmd;
   logic                 pop;
   logic                 q_empty;

   // front: counts pattern bytes, picks the bytes that still fall below n,
   // builds the big-endian low word and marks the cluster end
   cth_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .cmd_full (q_full),
      .cmd_data (push_cmd),
      .cmd_push (push)
   );

   // decoupling queue; a full queue is what stalls the item input
   cth_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (head_cmd),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: little-endian word gather, per-word multiply mix, tail and final mix,
   // then the result register that parts the back end from the response side
   cth_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (head_cmd),
      .cmd_empty (q_empty),
      .cmd_pop   (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

/* hw/rtl/cth_checker.sv */
// port-level checker of the cluster topology hash, bound to the top level
// depends on cluster_topology_hash_assert.svh and cluster_topology_hash
`timescale 1ns / 1ps
`default_nettype none

`include "cluster_topology_hash_assert.svh"

module cth_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_topology_hash,
   input wire logic        rsp_empty_error
);

   // a stalled item stays offered
   `CTH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped while stalled")

   // and keeps its payload
   `CTH_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_topology_hash) && $stable(rsp_empty_error), "rsp payload changed while stalled")

   // an empty cluster carries no hash
   `CTH_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid && rsp_empty_error, rsp_topology_hash == 64'd0, "empty cluster with nonzero hash")

   // nothing is offered right after reset
   `CTH_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid, "rsp valid after reset")

endmodule

bind cluster_topology_hash cth_checker u_cth_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_topology_hash (rsp_ch.topology_hash),
   .rsp_empty_error   (rsp_ch.empty_error)
);

`default_nettype wire

/* verif/cth_tb_pkg.sv */
// scoreboard class for the cluster topology hash testbench: predicts each result
// from the accepted items and checks the result stream; depends on nothing
`timescale 1ns / 1ps

package cth_tb_pkg;

   localparam bit [31:0] MURMUR_M  = 32'h5bd1e995;
   localparam bit [31:0] SEED_XOR  = 32'hdeadbeef;
   localparam int        PRINT_CAP = 40;

   typedef struct {
      logic [63:0] topology_hash;
      logic        empty_error;
   } cth_result_type;

   class cth_scoreboard;
      // predicted block state
      bit [31:0]   run_hash;
      bit [31:0]   word_buf;
      bit [31:0]   lead_bytes;
      int unsigned word_fill;
      int unsigned taken;
      int unsigned expected_len;

      cth_result_type pending_q[$];
      int unsigned mismatches;
      int unsigned results_checked;
      int unsigned empty_seen;
      int unsigned items_used;

      function new();
         run_hash     = 0;
         word_buf     = 0;
         lead_bytes   = 0;
         word_fill    = 0;
         taken        = 0;
         expected_len = 0;
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
      endtask

      // one byte at a stream position; bytes past the cluster length stay out
      function void mix_byte(int unsigned pos, bit [7:0] b);
         bit [31:0] k;
         if (pos >= expected_len)
            return;
         word_buf |= {24'd0, b} << (8 * word_fill);
         word_fill++;
         if (word_fill == 4) begin
            k = word_buf * MURMUR_M;
            k ^= k >> 24;
            k = k * MURMUR_M;
            run_hash = run_hash * MURMUR_M;
            run_hash ^= k;
            word_buf  = 0;
            word_fill = 0;
         end
      endfunction

      function bit [31:0] final_mix();
         bit [31:0] h;
         h = run_hash;
         if (word_fill != 0) begin
            h ^= word_buf;
            h = h * MURMUR_M;
         end
         h ^= h >> 13;
         h = h * MURMUR_M;
         h ^= h >> 15;
         return h;
      endfunction

      // returns 1 when the item was used, 0 when the block ignores it
      function bit note_item(bit first, bit [7:0] rows, bit [7:0] cols, bit [7:0] patt);
         int unsigned    bit_total;
         bit [31:0]      h;
         cth_result_type res;
         if (first) begin
            bit_total    = int'(rows) * int'(cols);
            expected_len = (bit_total + 7) / 8;
            taken        = 0;
            word_buf     = 0;
            word_fill    = 0;
            lead_bytes   = 0;
            run_hash     = expected_len ^ SEED_XOR;
            if (expected_len == 0) begin
               run_hash          = 0;
               res.topology_hash = 64'd0;
               res.empty_error   = 1'b1;
               pending_q.push_back(res);
               items_used++;
               return 1'b1;
            end
            mix_byte(0, rows);
            mix_byte(1, cols);
         end else if (taken >= expected_len) begin
            return 1'b0;
         end
         mix_byte(taken + 2, patt);
         if (taken < 4)
            lead_bytes |= {24'd0, patt} << (24 - 8 * taken);
         taken++;
         items_used++;
         if (taken == expected_len) begin
            h                 = final_mix();
            run_hash          = h;
            res.topology_hash = {h, lead_bytes};
            res.empty_error   = 1'b0;
            pending_q.push_back(res);
         end
         return 1'b1;
      endfunction

      task check_result(logic [63:0] hash, logic empty);
         cth_result_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result hash=%h empty=%b", hash, empty));
            return;
         end
         want = pending_q.pop_front();
         results_checked++;
         if (want.empty_error)
            empty_seen++;
         if (want.topology_hash !== hash)
            report($sformatf("topology_hash got %h want %h", hash, want.topology_hash));
         if (want.empty_error !== empty)
            report($sformatf("empty_error got %b want %b", empty, want.empty_error));
      endtask
   endclass

endpackage

/* verif/tb_top.sv */
// top of the cluster topology hash testbench: clock, reset, item drivers and checks
// depends on cth_tb_pkg, cth_if and the cluster_topology_hash rtl
`timescale 1ns / 1ps

module tb_top;

   logic clock;
   logic reset;

   cth_req_if req_bus ();
   cth_rsp_if rsp_bus ();

   cluster_topology_hash u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   cth_tb_pkg::cth_scoreboard sb = new();

   // idling is switched off for a stretch of items in the middle of the run
   bit          steady_run;
   int unsigned clusters_sent;

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // every block input known from time zero
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.first        = 1'b0;
      req_bus.row_count    = 8'd0;
      req_bus.col_count    = 8'd0;
      req_bus.pattern_byte = 8'd0;
      rsp_bus.ready        = 1'b0;
   end

   // result side stalls about 37 percent of the time outside the steady stretch
   always @(posedge clock) begin
      rsp_bus.ready <= !reset && (steady_run || ($urandom_range(0, 99) >= 37));
   end

   // both handshakes seen at the same edge; items noted before results checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            void'(sb.note_item(req_bus.first, req_bus.row_count, req_bus.col_count,
                               req_bus.pattern_byte));
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.topology_hash, rsp_bus.empty_error);
      end
   end

   // drive one item and hold it until the block takes it
   // valid stays high into the next item unless a random gap comes first
   task send_item(input bit first, input bit [7:0] rows, input bit [7:0] cols,
                  input bit [7:0] patt);
      while (!steady_run && ($urandom_range(0, 99) < 37)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.first        <= first;
      req_bus.row_count    <= rows;
      req_bus.col_count    <= cols;
      req_bus.pattern_byte <= patt;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   // start item plus count-1 following items with random pattern bytes;
   // size fields carry noise on the following items since the block ignores them
   task send_cluster(input bit [7:0] rows, input bit [7:0] cols, input int unsigned count);
      send_item(1'b1, rows, cols, 8'($urandom));
      for (int unsigned i = 1; i < count; i++)
         send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
      clusters_sent++;
   endtask

   initial begin
      bit [7:0]    rows;
      bit [7:0]    cols;
      bit [7:0]    swap;
      int unsigned sel;
      int unsigned n_bytes;
      int unsigned count;
      int unsigned big_at;

      steady_run    = 1'b0;
      clusters_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---------------- directed part ----------------
      // empty cluster with zero sizes, then with a full row count
      send_item(1'b1, 8'd0, 8'd0, 8'hff);
      send_item(1'b1, 8'hff, 8'd0, 8'h00);
      // item with no cluster open is dropped by the block
      send_item(1'b0, 8'h00, 8'hff, 8'haa);
      // one-byte clusters: only the row count reaches the hash
      send_item(1'b1, 8'd1, 8'd1, 8'hff);
      send_item(1'b1, 8'd1, 8'd8, 8'h00);
      // two bytes: header word of row and column only
      send_item(1'b1, 8'd2, 8'd8, 8'h5a);
      send_item(1'b0, 8'hff, 8'h00, 8'ha5);
      // a three-byte tail, then one full word, reaching into the first pattern bytes
      send_cluster(8'd3, 8'd8, 3);
      send_cluster(8'd4, 8'd8, 4);
      // restart: a new start item drops the open cluster
      send_cluster(8'd5, 8'd8, 2);
      send_cluster(8'd1, 8'd9, 2);

      // ---------------- random part ----------------
      // mostly whole clusters of small size, some cut short by a restart,
      // some stray items between clusters, one cluster of the largest size
      // that a restart cuts short so the item budget holds
      big_at = $urandom_range(20, 60);
      while (sb.items_used < 1400) begin
         steady_run = (sb.items_used >= 500) && (sb.items_used < 800);
         sel        = $urandom_range(0, 99);
         if (clusters_sent == big_at) begin
            rows = 8'd255;
            cols = 8'd255;
         end else if (sel < 60) begin
            rows = 8'($urandom_range(0, 8));
            cols = 8'($urandom_range(0, 8));
         end else if (sel < 85) begin
            rows = 8'($urandom_range(1, 16));
            cols = 8'($urandom_range(1, 16));
         end else begin
            // one side anywhere in its range, the other narrow
            rows = 8'($urandom);
            cols = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1) begin
               swap = rows;
               rows = cols;
               cols = swap;
            end
         end
         n_bytes = (int'(rows) * int'(cols) + 7) / 8;
         count   = (n_bytes == 0) ? 1 : n_bytes;
         if ((n_bytes >= 2) && ($urandom_range(0, 99) < 8))
            count = $urandom_range(1, n_bytes - 1);
         if (clusters_sent == big_at)
            count = $urandom_range(1, 64);
         send_cluster(rows, cols, count);
         // stray items only once the cluster is closed, so the block drops them
         if ((count == n_bytes || n_bytes == 0) && ($urandom_range(0, 99) < 5))
            repeat ($urandom_range(1, 3))
               send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      steady_run = 1'b0;
      req_bus.valid <= 1'b0;

      // let the last accepted item reach the scoreboard, drain,
      // then allow for the block's longest latency
      @(posedge clock);
      while (sb.pending_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      $display("run covered %0d pattern items in %0d clusters", sb.items_used,
               clusters_sent);
      $display("%0d results checked, %0d of them empty clusters", sb.results_checked,
               sb.empty_seen);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("timeout with %0d results still awaited", sb.pending_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/cth_pkg.sv
hw/rtl/cth_if.sv
hw/rtl/cth_front.sv
hw/rtl/cth_queue.sv
hw/rtl/cth_back.sv
hw/rtl/cluster_topology_hash.sv
hw/rtl/cth_checker.sv
verif/cth_tb_pkg.sv
verif/tb_top.sv
